### rtl/core/stp_pkg.sv
// Shared types and constants for the subtitle style tag parser.
package stp_pkg;

  localparam logic [7:0] ChOpen      = 8'h7B;  // {
  localparam logic [7:0] ChClose     = 8'h7D;  // }
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChUpperN    = 8'h4E;
  localparam logic [7:0] ChLowerN    = 8'h6E;
  localparam logic [7:0] ChLowerB    = 8'h62;
  localparam logic [7:0] ChLowerI    = 8'h69;
  localparam logic [7:0] ChLowerC    = 8'h63;
  localparam logic [7:0] ChOne       = 8'h31;
  localparam logic [7:0] ChZero      = 8'h30;
  localparam logic [7:0] ChAmp       = 8'h26;
  localparam logic [7:0] ChUpperH    = 8'h48;
  localparam logic [7:0] ChLowerH    = 8'h68;
  localparam logic [2:0] HexDigits   = 3'd6;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [1:0] CfgRed   = 2'd0;
  localparam logic [1:0] CfgGreen = 2'd1;
  localparam logic [1:0] CfgBlue  = 2'd2;

  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_BREAK = 2'd1,
    KIND_END   = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    M_PLAIN  = 4'd0,
    M_IDLE   = 4'd1,
    M_BSL    = 4'd2,
    M_B      = 4'd3,
    M_I      = 4'd4,
    M_ONE    = 4'd5,
    M_C      = 4'd6,
    M_AMP    = 4'd7,
    M_HEX    = 4'd8,
    M_HEXEND = 4'd9
  } mode_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  glyph;
    logic        bold;
    logic        italic;
    logic [23:0] rgb;
    logic        final_item;
  } res_t;

  typedef struct packed {
    logic [1:0]     cnt;
    res_t [1:0]     item;
  } res_pair_t;

endpackage

### rtl/core/stp_parser.sv
// Tag decoder: parse state and up to two result beats per input byte.
module stp_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          char_in_i,
  input  logic                line_end_i,
  input  logic [23:0]         def_rgb_i,
  output stp_pkg::res_pair_t  res_o
);
  import stp_pkg::*;

  mode_e       mode_q, mode_d;
  logic        held_q, held_d;
  logic        bold_q, bold_d;
  logic        italic_q, italic_d;
  logic [23:0] colour_q, colour_d;
  logic        cvalid_q, cvalid_d;
  logic [23:0] hshift_q, hshift_d;
  logic [2:0]  hcount_q, hcount_d;
  logic [2:0]  hbad_q, hbad_d;

  logic [23:0] cur_rgb;
  logic        do_plain;
  logic [1:0]  n;
  res_t [1:0]  res;
  logic [4:0]  hv;
  logic [1:0]  pair;
  logic [23:0] new_shift;
  logic [2:0]  new_bad;
  logic [2:0]  new_count;

  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    v = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) v = {1'b1, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      v = {1'b1, c[3:0] + 4'd9};
    return v;
  endfunction

  function automatic res_t mk_char(input logic [7:0] c, input logic b, input logic it,
                                   input logic [23:0] rgb);
    res_t r;
    r.kind       = KIND_CHAR;
    r.glyph      = c;
    r.bold       = b;
    r.italic     = it;
    r.rgb        = rgb;
    r.final_item = 1'b0;
    return r;
  endfunction

  assign cur_rgb   = cvalid_q ? colour_q : def_rgb_i;
  assign hv        = hex_val(char_in_i);
  assign pair      = hcount_q[2:1];
  assign new_shift = {hshift_q[19:0], hv[4] ? hv[3:0] : 4'd0};
  assign new_bad   = hv[4] ? hbad_q : (hbad_q | (3'b001 << pair));
  assign new_count = hcount_q + 3'd1;

  always_comb begin
    mode_d   = mode_q;
    held_d   = held_q;
    bold_d   = bold_q;
    italic_d = italic_q;
    colour_d = colour_q;
    cvalid_d = cvalid_q;
    hshift_d = hshift_q;
    hcount_d = hcount_q;
    hbad_d   = hbad_q;
    res      = '0;
    n        = 2'd0;
    do_plain = 1'b0;

    if (mode_q == M_PLAIN) begin
      if (held_q) begin
        held_d = 1'b0;
        if (char_in_i == ChUpperN || char_in_i == ChLowerN) begin
          res[0].kind = KIND_BREAK;
          res[0].rgb  = def_rgb_i;
          n = 2'd1;
        end else begin
          res[0]   = mk_char(ChBackslash, bold_q, italic_q, cur_rgb);
          n        = 2'd1;
          do_plain = 1'b1;
        end
      end else begin
        do_plain = 1'b1;
      end
    end else if (char_in_i == ChClose) begin
      mode_d = M_PLAIN;
    end else begin
      case (mode_q)
        M_BSL: begin
          if (char_in_i == ChLowerB) mode_d = M_B;
          else if (char_in_i == ChLowerI) mode_d = M_I;
          else if (char_in_i == ChLowerC) mode_d = M_C;
          else if (char_in_i == ChOne) mode_d = M_ONE;
          else mode_d = (char_in_i == ChBackslash) ? M_BSL : M_IDLE;
        end
        M_B: begin
          if (char_in_i == ChOne) begin
            bold_d = 1'b1;
            mode_d = M_IDLE;
          end else if (char_in_i == ChZero) begin
            bold_d = 1'b0;
            mode_d = M_IDLE;
          end else mode_d = (char_in_i == ChBackslash) ? M_BSL : M_IDLE;
        end
        M_I: begin
          if (char_in_i == ChOne) begin
            italic_d = 1'b1;
            mode_d   = M_IDLE;
          end else if (char_in_i == ChZero) begin
            italic_d = 1'b0;
            mode_d   = M_IDLE;
          end else mode_d = (char_in_i == ChBackslash) ? M_BSL : M_IDLE;
        end
        M_ONE: begin
          if (char_in_i == ChLowerC) mode_d = M_C;
          else mode_d = (char_in_i == ChBackslash) ? M_BSL : M_IDLE;
        end
        M_C: begin
          if (char_in_i == ChAmp) mode_d = M_AMP;
          else mode_d = (char_in_i == ChBackslash) ? M_BSL : M_IDLE;
        end
        M_AMP: begin
          if (char_in_i == ChUpperH || char_in_i == ChLowerH) begin
            mode_d   = M_HEX;
            hshift_d = '0;
            hcount_d = '0;
            hbad_d   = '0;
          end else mode_d = (char_in_i == ChBackslash) ? M_BSL : M_IDLE;
        end
        M_HEX: begin
          if (char_in_i == ChAmp) begin
            mode_d = M_IDLE;
          end else begin
            hshift_d = new_shift;
            hbad_d   = new_bad;
            hcount_d = new_count;
            if (new_count >= HexDigits) begin
              colour_d[23:16] = new_bad[2] ? 8'd0 : new_shift[7:0];
              colour_d[15:8]  = new_bad[1] ? 8'd0 : new_shift[15:8];
              colour_d[7:0]   = new_bad[0] ? 8'd0 : new_shift[23:16];
              cvalid_d        = 1'b1;
              mode_d          = M_HEXEND;
            end
          end
        end
        M_HEXEND: begin
          if (char_in_i == ChAmp) mode_d = M_IDLE;
          else mode_d = (char_in_i == ChBackslash) ? M_BSL : M_IDLE;
        end
        default: begin
          mode_d = (char_in_i == ChBackslash) ? M_BSL : M_IDLE;
        end
      endcase
    end

    if (do_plain) begin
      if (char_in_i == ChOpen) begin
        mode_d = M_IDLE;
      end else if (char_in_i == ChBackslash && !line_end_i) begin
        held_d = 1'b1;
      end else begin
        res[n[0]] = mk_char(char_in_i, bold_q, italic_q, cur_rgb);
        n = n + 2'd1;
      end
    end

    if (line_end_i) begin
      if (n == 2'd0) begin
        res[0].kind = KIND_END;
        n = 2'd1;
      end
      res[n == 2'd2].final_item = 1'b1;
      mode_d   = M_PLAIN;
      held_d   = 1'b0;
      bold_d   = 1'b0;
      italic_d = 1'b0;
      colour_d = '0;
      cvalid_d = 1'b0;
      hshift_d = '0;
      hcount_d = '0;
      hbad_d   = '0;
    end
  end

  assign res_o.cnt  = n;
  assign res_o.item = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= M_PLAIN;
      held_q   <= 1'b0;
      bold_q   <= 1'b0;
      italic_q <= 1'b0;
      colour_q <= '0;
      cvalid_q <= 1'b0;
      hshift_q <= '0;
      hcount_q <= '0;
      hbad_q   <= '0;
    end else if (step_i) begin
      mode_q   <= mode_d;
      held_q   <= held_d;
      bold_q   <= bold_d;
      italic_q <= italic_d;
      colour_q <= colour_d;
      cvalid_q <= cvalid_d;
      hshift_q <= hshift_d;
      hcount_q <= hcount_d;
      hbad_q   <= hbad_d;
    end
  end

endmodule

### rtl/core/stp_queue.sv
// Result queue: takes up to two beats per cycle, hands out one per cycle while ready_i is high.
module stp_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  stp_pkg::res_pair_t pair_i,
  output logic               room_o,
  output logic               valid_o,
  input  logic               ready_i,
  output stp_pkg::res_t      head_o
);
  import stp_pkg::*;

  res_t [QDepth-1:0] mem_q;
  logic [QPtrW-1:0]  wr_q, rd_q;
  logic [QCntW-1:0]  cnt_q, cnt_d;
  logic [1:0]        push_n;
  logic              pop;
  logic [QPtrW-1:0]  wr_next;

  assign push_n  = push_i ? pair_i.cnt : 2'd0;
  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != '0);
  assign room_o  = (cnt_q <= QCntW'(QDepth - 2));
  assign head_o  = mem_q[rd_q];
  assign wr_next = wr_q + QPtrW'(1);
  assign cnt_d   = cnt_q + QCntW'(push_n) - QCntW'(pop);

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) mem_q[wr_q] <= pair_i.item[0];
    if (push_n == 2'd2) mem_q[wr_next] <= pair_i.item[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + QPtrW'(push_n);
      rd_q  <= rd_q + QPtrW'(pop);
      cnt_q <= cnt_d;
    end
  end

endmodule

### rtl/core/subtitle_style_tag_parser.sv
// Top level of the subtitle style tag parser.
// A result beat is written into the registered result queue when its input byte is taken.
// Throughput: one byte per cycle while bytes yield at most one beat each and the
// output is ready; the single output port carries one beat a cycle, so two-beat bytes hold the input back.
// A four-entry result queue decouples input from output stalls.
// Reset: default colour 255/255/255, plain text mode, queue empty.
module subtitle_style_tag_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_in_i,
  input  logic       line_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] kind_o,
  output logic [7:0] glyph_code_o,
  output logic       is_bold_o,
  output logic       is_italic_o,
  output logic [7:0] red_out_o,
  output logic [7:0] green_out_o,
  output logic [7:0] blue_out_o,
  output logic       final_item_o
);
  import stp_pkg::*;

  logic [7:0] def_red_q, def_green_q, def_blue_q;
  logic       step;
  logic       cfg_we;
  res_pair_t  pair;
  res_t       head;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign step        = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      def_red_q   <= 8'hFF;
      def_green_q <= 8'hFF;
      def_blue_q  <= 8'hFF;
    end else if (cfg_we) begin
      case (cfg_index_i)
        CfgRed:   def_red_q   <= cfg_data_i;
        CfgGreen: def_green_q <= cfg_data_i;
        CfgBlue:  def_blue_q  <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  stp_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .char_in_i  (char_in_i),
    .line_end_i (line_end_i),
    .def_rgb_i  ({def_red_q, def_green_q, def_blue_q}),
    .res_o      (pair)
  );

  stp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (step),
    .pair_i  (pair),
    .room_o  (in_ready_o),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .head_o  (head)
  );

  assign kind_o       = head.kind;
  assign glyph_code_o = head.glyph;
  assign is_bold_o    = head.bold;
  assign is_italic_o  = head.italic;
  assign red_out_o    = head.rgb[23:16];
  assign green_out_o  = head.rgb[15:8];
  assign blue_out_o   = head.rgb[7:0];
  assign final_item_o = head.final_item;

endmodule

### verif/subtitle_style_tag_parser_tb.sv
// Self-checking testbench for the subtitle style tag parser: directed and random tagged text lines.
`timescale 1ns / 100ps

module subtitle_style_tag_parser_tb;
  import stp_pkg::*;

  localparam int QuietLimit = 3000;
  localparam int SettleCycles = 8;
  localparam int PhaseCount = 8;
  localparam int PhaseBytes = 250;

  typedef struct {
    logic [7:0] ch;
    logic       last;
    bit         drain;
  } text_byte_t;

  typedef struct {
    kind_e      kind;
    logic [7:0] glyph;
    logic       bold;
    logic       italic;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } beat_t;

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i = CfgRed;
  logic [7:0] cfg_data_i = 8'h00;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] char_in_i = 8'h00;
  logic       line_end_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [1:0] kind_o;
  logic [7:0] glyph_code_o;
  logic       is_bold_o;
  logic       is_italic_o;
  logic [7:0] red_out_o;
  logic [7:0] green_out_o;
  logic [7:0] blue_out_o;
  logic       final_item_o;

  subtitle_style_tag_parser u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .char_in_i    (char_in_i),
    .line_end_i   (line_end_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .glyph_code_o (glyph_code_o),
    .is_bold_o    (is_bold_o),
    .is_italic_o  (is_italic_o),
    .red_out_o    (red_out_o),
    .green_out_o  (green_out_o),
    .blue_out_o   (blue_out_o),
    .final_item_o (final_item_o)
  );

  text_byte_t byte_q[$];
  beat_t      want_q[$];
  beat_t      line_beats[$];
  logic [7:0] line_buf[$];
  beat_t      got_head;
  int         n_queued = 0;
  int         n_taken = 0;
  int         n_errors = 0;
  int         phase_bytes = 0;
  int         gap_left = 0;
  int         stall_left = 0;
  bit         calm = 1'b0;

  // Shadow of the colour registers and the parser state
  logic [7:0]  dflt_red = 8'hFF;
  logic [7:0]  dflt_green = 8'hFF;
  logic [7:0]  dflt_blue = 8'hFF;
  mode_e       pmode = M_PLAIN;
  logic        bs_pending = 1'b0;
  logic        st_bold = 1'b0;
  logic        st_italic = 1'b0;
  logic [23:0] colour_rgb = '0;
  logic        colour_on = 1'b0;
  logic [23:0] hex_acc = '0;
  logic [2:0]  hex_cnt = '0;
  logic [2:0]  hex_bad = '0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void add_beat(kind_e k, logic [7:0] g, logic b, logic it,
                                   logic [7:0] r, logic [7:0] gr, logic [7:0] bl);
    beat_t bt;
    bt.kind = k;
    bt.glyph = g;
    bt.bold = b;
    bt.italic = it;
    bt.red = r;
    bt.green = gr;
    bt.blue = bl;
    bt.last = 1'b0;
    if (line_beats.size() < 2) line_beats = {line_beats, bt};
  endfunction

  function automatic void emit_glyph(logic [7:0] c);
    if (colour_on) begin
      add_beat(KIND_CHAR, c, st_bold, st_italic, colour_rgb[23:16], colour_rgb[15:8],
               colour_rgb[7:0]);
    end else begin
      add_beat(KIND_CHAR, c, st_bold, st_italic, dflt_red, dflt_green, dflt_blue);
    end
  endfunction

  function automatic void clear_line();
    pmode = M_PLAIN;
    bs_pending = 1'b0;
    st_bold = 1'b0;
    st_italic = 1'b0;
    colour_rgb = '0;
    colour_on = 1'b0;
    hex_acc = '0;
    hex_cnt = '0;
    hex_bad = '0;
  endfunction

  function automatic int hex_val(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  function automatic void to_idle(logic [7:0] c);
    pmode = (c == ChBackslash) ? M_BSL : M_IDLE;
  endfunction

  function automatic void take_hex(logic [7:0] c);
    int         v;
    logic [1:0] pair;
    v = hex_val(c);
    pair = hex_cnt[2:1];
    if (v < 0) begin
      v = 0;
      if (pair != 2'd3) hex_bad[pair] = 1'b1;
    end
    hex_acc = {hex_acc[19:0], 4'(v)};
    hex_cnt = hex_cnt + 3'd1;
    if (hex_cnt >= HexDigits) begin
      colour_rgb = {hex_bad[2] ? 8'h00 : hex_acc[7:0],
                    hex_bad[1] ? 8'h00 : hex_acc[15:8],
                    hex_bad[0] ? 8'h00 : hex_acc[23:16]};
      colour_on = 1'b1;
      pmode = M_HEXEND;
    end
  endfunction

  function automatic void tag_step(logic [7:0] c);
    if (c == ChClose) begin
      pmode = M_PLAIN;
      return;
    end
    case (pmode)
      M_BSL: begin
        if (c == ChLowerB) pmode = M_B;
        else if (c == ChLowerI) pmode = M_I;
        else if (c == ChLowerC) pmode = M_C;
        else if (c == ChOne) pmode = M_ONE;
        else to_idle(c);
      end
      M_B: begin
        if (c == ChOne || c == ChZero) begin
          st_bold = (c == ChOne);
          pmode = M_IDLE;
        end else to_idle(c);
      end
      M_I: begin
        if (c == ChOne || c == ChZero) begin
          st_italic = (c == ChOne);
          pmode = M_IDLE;
        end else to_idle(c);
      end
      M_ONE: begin
        if (c == ChLowerC) pmode = M_C;
        else to_idle(c);
      end
      M_C: begin
        if (c == ChAmp) pmode = M_AMP;
        else to_idle(c);
      end
      M_AMP: begin
        if (c == ChUpperH || c == ChLowerH) begin
          pmode = M_HEX;
          hex_acc = '0;
          hex_cnt = '0;
          hex_bad = '0;
        end else to_idle(c);
      end
      M_HEX: begin
        if (c == ChAmp) pmode = M_IDLE;
        else take_hex(c);
      end
      M_HEXEND: begin
        if (c == ChAmp) pmode = M_IDLE;
        else to_idle(c);
      end
      default: to_idle(c);
    endcase
  endfunction

  function automatic void plain_step(logic [7:0] c, logic last);
    if (c == ChOpen) pmode = M_IDLE;
    else if (c == ChBackslash) begin
      if (last) emit_glyph(c);
      else bs_pending = 1'b1;
    end else emit_glyph(c);
  endfunction

  function automatic void parse_byte(logic [7:0] c, logic last);
    beat_t tail;
    line_beats.delete();
    if (pmode == M_PLAIN) begin
      if (bs_pending) begin
        bs_pending = 1'b0;
        if (c == ChUpperN || c == ChLowerN) begin
          add_beat(KIND_BREAK, 8'h00, 1'b0, 1'b0, dflt_red, dflt_green, dflt_blue);
        end else begin
          emit_glyph(ChBackslash);
          plain_step(c, last);
        end
      end else plain_step(c, last);
    end else tag_step(c);
    if (last) begin
      if (line_beats.size() == 0) add_beat(KIND_END, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00);
      tail = line_beats.pop_back();
      tail.last = 1'b1;
      line_beats = {line_beats, tail};
      clear_line();
    end
    foreach (line_beats[k]) want_q = {want_q, line_beats[k]};
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Driver: present queued bytes, hold each until it is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      char_in_i <= 8'h00;
      line_end_i <= 1'b0;
      gap_left <= 0;
    end else if (!(in_valid_i && !in_ready_o)) begin
      if (in_valid_i) begin
        parse_byte(char_in_i, line_end_i);
        n_taken++;
      end
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (byte_q.size() != 0 && (!byte_q[0].drain || want_q.size() == 0)) begin
        in_valid_i <= 1'b1;
        char_in_i <= byte_q[0].ch;
        line_end_i <= byte_q[0].last;
        void'(byte_q.pop_front());
        gap_left <= calm ? 0 : pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      n_errors++;
    end
  endtask

  // Monitor: compare each result beat with the oldest prediction, stall at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (want_q.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual kind %0d glyph %0h", $time,
                   kind_o, glyph_code_o);
          n_errors++;
        end else begin
          got_head = want_q.pop_front();
          check_field("kind", got_head.kind, kind_o);
          check_field("glyph_code", got_head.glyph, glyph_code_o);
          check_field("is_bold", got_head.bold, is_bold_o);
          check_field("is_italic", got_head.italic, is_italic_o);
          check_field("red_out", got_head.red, red_out_o);
          check_field("green_out", got_head.green, green_out_o);
          check_field("blue_out", got_head.blue, blue_out_o);
          check_field("final_item", got_head.last, final_item_o);
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left <= pick_gap();
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) quiet = 0;
      else quiet++;
    end
    $display("subtitle_style_tag_parser_tb failed");
    $finish;
  end

  function automatic void push_byte(logic [7:0] c, logic last);
    text_byte_t tb;
    tb.ch = c;
    tb.last = last;
    tb.drain = ($urandom_range(0, 199) == 0);
    byte_q = {byte_q, tb};
    n_queued++;
    phase_bytes++;
  endfunction

  function automatic void add_ch(logic [7:0] c);
    line_buf = {line_buf, c};
  endfunction

  function automatic void push_text(string s, bit end_line);
    for (int k = 0; k < s.len(); k++) push_byte(s[k], end_line && (k == s.len() - 1));
  endfunction

  function automatic logic [7:0] text_char();
    int r;
    logic [7:0] specials[7];
    specials = '{ChOpen, ChClose, ChBackslash, ChUpperN, ChLowerN, ChAmp, ChUpperH};
    r = $urandom_range(0, 99);
    if (r < 70) return 8'($urandom_range(8'h20, 8'h7E));
    if (r < 90) return 8'($urandom_range(0, 255));
    return specials[$urandom_range(0, 6)];
  endfunction

  function automatic logic [7:0] hex_char();
    int v;
    if ($urandom_range(0, 11) == 0) return 8'($urandom_range(0, 255));
    v = $urandom_range(0, 15);
    if (v < 10) return 8'("0" + v);
    return 8'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
  endfunction

  function automatic void add_colour_tag();
    int n;
    add_ch(ChBackslash);
    if ($urandom_range(0, 1)) add_ch(ChOne);
    add_ch(ChLowerC);
    add_ch(ChAmp);
    if ($urandom_range(0, 9) != 0) add_ch($urandom_range(0, 1) ? ChUpperH : ChLowerH);
    else add_ch(text_char());
    n = ($urandom_range(0, 9) != 0) ? 6 : $urandom_range(0, 5);
    repeat (n) add_ch(hex_char());
    if ($urandom_range(0, 4) != 0) add_ch(ChAmp);
  endfunction

  function automatic void add_group();
    int r;
    add_ch(ChOpen);
    repeat ($urandom_range(1, 3)) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        add_ch(ChBackslash);
        add_ch($urandom_range(0, 1) ? ChLowerB : ChLowerI);
        if ($urandom_range(0, 19) != 0) add_ch($urandom_range(0, 1) ? ChOne : ChZero);
        else add_ch(text_char());
      end else if (r < 75) begin
        add_colour_tag();
      end else if (r < 90) begin
        add_ch(ChBackslash);
        add_ch(8'($urandom_range("a", "z")));
        if ($urandom_range(0, 1)) add_ch(text_char());
      end else begin
        add_ch(text_char());
      end
    end
    if ($urandom_range(0, 9) != 0) add_ch(ChClose);
  endfunction

  function automatic void gen_line(bit partial);
    int r;
    int n;
    line_buf.delete();
    if ($urandom_range(0, 99) < 85) begin
      repeat ($urandom_range(1, 6)) begin
        r = $urandom_range(0, 99);
        if (r < 35) repeat ($urandom_range(1, 5)) add_ch(text_char());
        else if (r < 75) add_group();
        else if (r < 90) begin
          add_ch(ChBackslash);
          add_ch($urandom_range(0, 1) ? ChUpperN : ChLowerN);
        end else begin
          add_ch(ChBackslash);
          if ($urandom_range(0, 3) != 0) add_ch(text_char());
        end
      end
    end else begin
      repeat ($urandom_range(1, 8)) add_ch(text_char());
    end
    n = partial ? $urandom_range(1, line_buf.size()) : line_buf.size();
    for (int k = 0; k < n; k++) push_byte(line_buf[k], !partial && (k == n - 1));
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    cfg_index_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgRed: dflt_red = val;
      CfgGreen: dflt_green = val;
      default: dflt_blue = val;
    endcase
  endtask

  task automatic wait_drained();
    while (!(n_taken == n_queued && want_q.size() == 0)) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_level();
    int r;
    r = $urandom_range(0, 3);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    logic [7:0] lv[3];
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_text("}\\N", 1'b1);
    push_text("{\\b1\\i1\\1c&Hg12345}A\\x", 1'b1);
    push_text("\\", 1'b1);
    push_text("{", 1'b1);
    wait_drained();

    for (int p = 0; p < PhaseCount; p++) begin
      repeat (SettleCycles) @(posedge clk_i);
      case (p)
        0: lv = '{8'h00, 8'h00, 8'h00};
        1: lv = '{8'hFF, 8'hFF, 8'hFF};
        2: lv = '{8'h00, 8'hFF, 8'h00};
        default: lv = '{pick_level(), pick_level(), pick_level()};
      endcase
      write_reg(CfgRed, lv[0]);
      write_reg(CfgGreen, lv[1]);
      write_reg(CfgBlue, lv[2]);
      cfg_valid_i <= 1'b0;
      calm = (p == 1) || ($urandom_range(0, 3) == 0);
      phase_bytes = 0;
      while (phase_bytes < PhaseBytes) gen_line(1'b0);
      if ($urandom_range(0, 9) < 3) gen_line(1'b1);
      wait_drained();
    end

    repeat (SettleCycles) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("subtitle_style_tag_parser_tb passed");
    end else begin
      $display("subtitle_style_tag_parser_tb failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/stp_pkg.sv
rtl/core/stp_parser.sv
rtl/core/stp_queue.sv
rtl/core/subtitle_style_tag_parser.sv
verif/subtitle_style_tag_parser_tb.sv
